FILE: rtl/binary_min_heap_queue_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the binary min-heap queue
// Concurrent checks sampled on clk_i and disabled while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef BINARY_MIN_HEAP_QUEUE_MACROS_SVH
`define BINARY_MIN_HEAP_QUEUE_MACROS_SVH

`ifndef SYNTHESIS

// Checks that a property holds at every clock edge outside of reset.
`define BMH_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error(msg);

// Checks that a condition is never true outside of reset.
`define BMH_ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) \
    else $error(msg);

`else

`define BMH_ASSERT(lbl, prop, msg)
`define BMH_ASSERT_NEVER(lbl, cond, msg)

`endif

`endif

FILE: rtl/bmh_pkg.sv
// ----------------------------------------------------------------------------
// Binary min-heap queue package
// Sizes, codes, controller states and the control/status bundles.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package bmh_pkg;

  localparam int CAPACITY  = 64;
  localparam int KEY_WIDTH = 32;
  localparam int IO_KEY_W  = 32;
  localparam int IDX_W     = $clog2(CAPACITY);
  localparam int CNT_W     = $clog2(CAPACITY + 1);

  typedef logic signed [KEY_WIDTH-1:0] key_t;

  typedef enum logic {
    CMD_INSERT = 1'b0,
    CMD_DELETE = 1'b1
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_UP_CHK,
    S_UP_CMP,
    S_DN_LOAD,
    S_DN_CHK,
    S_DN_CMP,
    S_FINISH
  } state_e;

  typedef struct packed {
    logic accept;     // take the input word
    logic load_key;   // moving key from the read port (delete)
    logic rd_parent;  // port A reads the parent of pos, else the left child (the last entry on accept)
    logic wr_key;     // write the moving key at pos
    logic move_up;    // parent drops into pos, pos climbs
    logic move_dn;    // picked child rises into pos, pos descends
    logic out_load;   // load the result register
  } ctl_t;

  typedef struct packed {
    logic full;
    logic empty;
    logic pos_zero;
    logic left_out;   // left child lies beyond the last entry
    logic parent_gt;  // parent key greater than the moving key
    logic child_gt;   // moving key greater than the smaller child
    logic out_busy;   // result register holds a word that is stalled
  } sts_t;

  // Sign-extend or truncate a port key into the stored key width.
  function automatic key_t to_key(input logic [IO_KEY_W-1:0] x);
    logic signed [63:0] w;
    w = 64'(signed'(x));
    return w[KEY_WIDTH-1:0];
  endfunction

  // Sign-extend or truncate a stored key into the port key width.
  function automatic logic [IO_KEY_W-1:0] from_key(input key_t k);
    logic signed [63:0] w;
    w = 64'(k);
    return w[IO_KEY_W-1:0];
  endfunction

endpackage

FILE: rtl/bmh_ctrl.sv
// ----------------------------------------------------------------------------
// Binary min-heap controller
// Sequences accept, sift-up, sift-down and result hand-off.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bmh_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  input  logic          cmd_i,
  output logic          in_stall_o,
  input  bmh_pkg::sts_t sts_i,
  output bmh_pkg::ctl_t ctl_o
);

  bmh_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= bmh_pkg::S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_stall_o = (state_q != bmh_pkg::S_IDLE);

  always_comb begin
    state_d = state_q;
    ctl_o   = '0;
    case (state_q)
      bmh_pkg::S_IDLE: begin
        if (in_valid_i) begin
          ctl_o.accept = 1'b1;
          if (cmd_i == bmh_pkg::CMD_INSERT) begin
            state_d = sts_i.full ? bmh_pkg::S_FINISH : bmh_pkg::S_UP_CHK;
          end else begin
            state_d = sts_i.empty ? bmh_pkg::S_FINISH : bmh_pkg::S_DN_LOAD;
          end
        end
      end
      bmh_pkg::S_UP_CHK: begin
        if (sts_i.pos_zero) begin
          ctl_o.wr_key = 1'b1;
          state_d      = bmh_pkg::S_FINISH;
        end else begin
          ctl_o.rd_parent = 1'b1;
          state_d         = bmh_pkg::S_UP_CMP;
        end
      end
      bmh_pkg::S_UP_CMP: begin
        if (sts_i.parent_gt) begin
          ctl_o.move_up = 1'b1;
          state_d       = bmh_pkg::S_UP_CHK;
        end else begin
          ctl_o.wr_key = 1'b1;
          state_d      = bmh_pkg::S_FINISH;
        end
      end
      bmh_pkg::S_DN_LOAD: begin
        ctl_o.load_key = 1'b1;
        state_d        = bmh_pkg::S_DN_CHK;
      end
      bmh_pkg::S_DN_CHK: begin
        if (sts_i.left_out) begin
          ctl_o.wr_key = 1'b1;
          state_d      = bmh_pkg::S_FINISH;
        end else begin
          state_d = bmh_pkg::S_DN_CMP;
        end
      end
      bmh_pkg::S_DN_CMP: begin
        if (sts_i.child_gt) begin
          ctl_o.move_dn = 1'b1;
          state_d       = bmh_pkg::S_DN_CHK;
        end else begin
          ctl_o.wr_key = 1'b1;
          state_d      = bmh_pkg::S_FINISH;
        end
      end
      bmh_pkg::S_FINISH: begin
        if (!sts_i.out_busy) begin
          ctl_o.out_load = 1'b1;
          state_d        = bmh_pkg::S_IDLE;
        end
      end
      default: begin
        state_d = bmh_pkg::S_IDLE;
      end
    endcase
  end

endmodule

FILE: rtl/bmh_dpath.sv
// ----------------------------------------------------------------------------
// Binary min-heap datapath
// Key memory, moving key, position, entry count, root copy and result word.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "binary_min_heap_queue_macros.svh"

module bmh_dpath (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  bmh_pkg::ctl_t                ctl_i,
  output bmh_pkg::sts_t                sts_o,
  input  logic                         cmd_i,
  input  logic [bmh_pkg::IO_KEY_W-1:0] key_in_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [1:0]                   status_o,
  output logic [bmh_pkg::IO_KEY_W-1:0] min_key_o,
  output logic                         is_empty_o,
  output logic [6:0]                   entry_count_o
);

  localparam int IW = bmh_pkg::IDX_W;
  localparam int CW = bmh_pkg::CNT_W;
  localparam int LW = bmh_pkg::IDX_W + 2;

  // Key memory: one write port at pos, two registered read ports.
  bmh_pkg::key_t mem_q [bmh_pkg::CAPACITY];
  bmh_pkg::key_t rd_a_q, rd_b_q;

  bmh_pkg::key_t    key_q, key_d;
  bmh_pkg::key_t    min_q;
  logic [IW-1:0]    pos_q, pos_d;
  logic [CW-1:0]    count_q, count_d;
  bmh_pkg::status_e op_st_q, op_st_d;

  logic                         out_valid_q;
  bmh_pkg::status_e             out_status_q;
  logic [bmh_pkg::IO_KEY_W-1:0] out_min_q;
  logic                         out_empty_q;
  logic [CW-1:0]                out_count_q;

  logic [IW-1:0] parent_idx;
  logic [LW-1:0] left_idx, right_idx;
  logic          right_in;
  logic          pick_right;
  logic [IW-1:0] pick_idx;
  bmh_pkg::key_t pick_val;
  logic [IW-1:0] rd_addr_a, rd_addr_b;
  logic          wr_en;
  bmh_pkg::key_t wr_data;
  logic          full, empty;

  assign full       = (count_q == CW'(bmh_pkg::CAPACITY));
  assign empty      = (count_q == '0);
  assign parent_idx = (pos_q - IW'(1)) >> 1;
  assign left_idx   = {1'b0, pos_q, 1'b1};
  assign right_idx  = LW'({1'b0, pos_q} + (IW + 1)'(1)) << 1;
  assign right_in   = (right_idx < LW'(count_q));
  assign pick_right = right_in && (rd_a_q > rd_b_q);
  assign pick_idx   = pick_right ? right_idx[IW-1:0] : left_idx[IW-1:0];
  assign pick_val   = pick_right ? rd_b_q : rd_a_q;

  // On accept of a delete, port A fetches the last entry.
  always_comb begin
    if (ctl_i.accept) begin
      rd_addr_a = IW'(count_q - CW'(1));
    end else if (ctl_i.rd_parent) begin
      rd_addr_a = parent_idx;
    end else begin
      rd_addr_a = left_idx[IW-1:0];
    end
    rd_addr_b = right_idx[IW-1:0];
  end

  assign wr_en   = ctl_i.wr_key | ctl_i.move_up | ctl_i.move_dn;
  assign wr_data = ctl_i.wr_key ? key_q : (ctl_i.move_up ? rd_a_q : pick_val);

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[pos_q] <= wr_data;
    end
    rd_a_q <= mem_q[rd_addr_a];
    rd_b_q <= mem_q[rd_addr_b];
  end

  // Every change of the root goes through a write at position zero.
  always_ff @(posedge clk_i) begin
    if (wr_en && (pos_q == '0)) begin
      min_q <= wr_data;
    end
  end

  always_comb begin
    key_d   = key_q;
    pos_d   = pos_q;
    count_d = count_q;
    op_st_d = op_st_q;
    if (ctl_i.accept) begin
      op_st_d = bmh_pkg::ST_OK;
      if (cmd_i == bmh_pkg::CMD_INSERT) begin
        if (full) begin
          op_st_d = bmh_pkg::ST_FULL;
        end else begin
          key_d   = bmh_pkg::to_key(key_in_i);
          pos_d   = IW'(count_q);
          count_d = count_q + CW'(1);
        end
      end else begin
        if (empty) begin
          op_st_d = bmh_pkg::ST_EMPTY;
        end else begin
          pos_d   = '0;
          count_d = count_q - CW'(1);
        end
      end
    end
    if (ctl_i.load_key) begin
      key_d = rd_a_q;
    end
    if (ctl_i.move_up) begin
      pos_d = parent_idx;
    end
    if (ctl_i.move_dn) begin
      pos_d = pick_idx;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q   <= key_d;
    pos_q   <= pos_d;
    op_st_q <= op_st_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else begin
      count_q <= count_d;
    end
  end

  // Result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (ctl_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.out_load) begin
      out_status_q <= op_st_q;
      out_min_q    <= empty ? '0 : bmh_pkg::from_key(min_q);
      out_empty_q  <= empty;
      out_count_q  <= count_q;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign status_o      = out_status_q;
  assign min_key_o     = out_min_q;
  assign is_empty_o    = out_empty_q;
  assign entry_count_o = 7'(out_count_q);

  assign sts_o.full      = full;
  assign sts_o.empty     = empty;
  assign sts_o.pos_zero  = (pos_q == '0);
  assign sts_o.left_out  = (left_idx >= LW'(count_q));
  assign sts_o.parent_gt = (rd_a_q > key_q);
  assign sts_o.child_gt  = (key_q > pick_val);
  assign sts_o.out_busy  = out_valid_q && out_stall_i;

  `BMH_ASSERT_NEVER(a_count_range, count_q > CW'(bmh_pkg::CAPACITY), "entry count above capacity")
  `BMH_ASSERT(a_ins_count, (ctl_i.accept && cmd_i == bmh_pkg::CMD_INSERT && !full) |=> (count_q == $past(count_q) + CW'(1)), "insert did not grow the heap by one")
  `BMH_ASSERT(a_move_up_root, ctl_i.move_up |-> (pos_q != '0), "sift-up moved past the root")
  `BMH_ASSERT(a_move_dn_deeper, ctl_i.move_dn |-> (pick_idx > pos_q), "sift-down did not descend")

endmodule

FILE: rtl/binary_min_heap_queue.sv
// ----------------------------------------------------------------------------
// Binary min-heap queue
// Priority queue of signed keys with insert and delete-min commands.
// ----------------------------------------------------------------------------
// Usage: the input channel carries one command word (cmd_i, key_in_i) with
// in_valid_i; the block raises in_stall_o from the cycle after acceptance
// until the command's result has been placed in the output register. Every
// command yields exactly one result word on the output channel: status_o,
// min_key_o (zero when empty), is_empty_o and entry_count_o, qualified by
// out_valid_o and held while out_stall_i is high.
// Sequencing: one command is handled at a time. An insert reads the parent and
// then compares and writes for each level the key climbs, plus one final check;
// a delete first loads the last entry, then reads and compares for each level
// it sinks, plus one final check, as each level needs a registered read of the
// key memory before the compare and write. The result register is then loaded,
// and the next word can be taken in the cycle after that load. Rejected commands
// (insert when full, delete when empty) go from acceptance straight to the final
// state and load their result there.
// The output register lets the next command be accepted while a result still
// waits; a result that finds the register stalled waits in its final state.
// Reset empties the heap at once; key memory contents need no clearing.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module binary_min_heap_queue (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic                         cmd_i,
  input  logic [bmh_pkg::IO_KEY_W-1:0] key_in_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [1:0]                   status_o,
  output logic [bmh_pkg::IO_KEY_W-1:0] min_key_o,
  output logic                         is_empty_o,
  output logic [6:0]                   entry_count_o
);

  bmh_pkg::ctl_t ctl;
  bmh_pkg::sts_t sts;

  bmh_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .cmd_i      (cmd_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .ctl_o      (ctl)
  );

  bmh_dpath u_dpath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .ctl_i         (ctl),
    .sts_o         (sts),
    .cmd_i         (cmd_i),
    .key_in_i      (key_in_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .status_o      (status_o),
    .min_key_o     (min_key_o),
    .is_empty_o    (is_empty_o),
    .entry_count_o (entry_count_o)
  );

endmodule

FILE: tb/tb.sv
// ----------------------------------------------------------------------------
// Testbench for the binary min-heap queue
// Directed and random insert and delete-min command words go in while result
// words are checked against a heap predictor kept in the bench.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;

  typedef struct {
    bmh_pkg::cmd_e op;
    logic [31:0]   key;
    bit            wait_drain;   // hold this word back until every result is out
  } heap_cmd_t;

  typedef struct {
    bmh_pkg::status_e status;
    logic [31:0]      min_key;
    logic             is_empty;
    logic [6:0]       count;
  } heap_report_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic        cmd = 1'b0;
  logic [31:0] key_in = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [1:0]  status;
  logic [31:0] min_key;
  logic        is_empty;
  logic [6:0]  entry_count;

  heap_cmd_t     cmd_q[$];
  heap_report_t  report_q[$];
  bmh_pkg::key_t heap_keys[bmh_pkg::CAPACITY];
  int            heap_fill = 0;
  int            total_cmds = 0;
  int            sent_cnt = 0;
  int            got_cnt = 0;
  int            fail_cnt = 0;
  int            hold_left = 0;

  always #5 clk = ~clk;

  binary_min_heap_queue dut (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .in_valid_i    (in_valid),
    .in_stall_o    (in_stall),
    .cmd_i         (cmd),
    .key_in_i      (key_in),
    .out_valid_o   (out_valid),
    .out_stall_i   (out_stall),
    .status_o      (status),
    .min_key_o     (min_key),
    .is_empty_o    (is_empty),
    .entry_count_o (entry_count)
  );

  // Applies one command to the bench copy of the heap and returns its report.
  function automatic heap_report_t heap_apply(bmh_pkg::cmd_e op, logic [31:0] raw);
    heap_report_t  r;
    int            pos;
    int            up;
    int            kid;
    bmh_pkg::key_t tmp;
    r.status = bmh_pkg::ST_OK;
    if (op == bmh_pkg::CMD_INSERT) begin
      if (heap_fill >= bmh_pkg::CAPACITY) begin
        r.status = bmh_pkg::ST_FULL;
      end else begin
        heap_keys[heap_fill] = bmh_pkg::key_t'($signed(raw));
        pos = heap_fill;
        heap_fill++;
        while (pos > 0) begin
          up = (pos - 1) / 2;
          if (!(heap_keys[up] > heap_keys[pos])) break;
          tmp = heap_keys[up];
          heap_keys[up] = heap_keys[pos];
          heap_keys[pos] = tmp;
          pos = up;
        end
      end
    end else if (heap_fill == 0) begin
      r.status = bmh_pkg::ST_EMPTY;
    end else begin
      heap_keys[0] = heap_keys[heap_fill-1];
      heap_fill--;
      pos = 0;
      while (2 * pos + 1 < heap_fill) begin
        kid = 2 * pos + 1;
        // On equal children the left one is kept.
        if (kid + 1 < heap_fill && heap_keys[kid] > heap_keys[kid+1]) kid++;
        if (!(heap_keys[pos] > heap_keys[kid])) break;
        tmp = heap_keys[pos];
        heap_keys[pos] = heap_keys[kid];
        heap_keys[kid] = tmp;
        pos = kid;
      end
    end
    r.min_key  = (heap_fill != 0) ? 32'(heap_keys[0]) : '0;
    r.is_empty = (heap_fill == 0);
    r.count    = 7'(heap_fill);
    return r;
  endfunction

  function automatic logic [31:0] random_key();
    int sel;
    sel = $urandom_range(99);
    if (sel < 60) return $urandom;
    if (sel < 80) return 32'($signed($urandom_range(15)) - 8);
    if (sel < 90) begin
      case ($urandom_range(3))
        0: return 32'h8000_0000;
        1: return 32'h7FFF_FFFF;
        2: return 32'h0000_0000;
        default: return 32'hFFFF_FFFF;
      endcase
    end
    return {1'($urandom_range(1)), 27'd0, 4'($urandom_range(15))};
  endfunction

  function automatic void add_cmd(bmh_pkg::cmd_e op, logic [31:0] k);
    heap_cmd_t c;
    c.op = op;
    c.key = k;
    c.wait_drain = ($urandom_range(149) == 0);
    cmd_q = {cmd_q, c};
  endfunction

  // Sender: offers queued command words and predicts each accepted one.
  always @(posedge clk) begin
    int           sent_now;
    int           idle_pct;
    bit           fire;
    heap_report_t exp_new;
    fire = in_valid && !in_stall;
    sent_now = sent_cnt + (fire ? 1 : 0);
    case ((sent_cnt * 3) / (total_cmds + 1))
      0: idle_pct = 17;
      1: idle_pct = 77;
      default: idle_pct = 0;
    endcase
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (fire) begin
        exp_new = heap_apply(bmh_pkg::cmd_e'(cmd), key_in);
        report_q = {report_q, exp_new};
        sent_cnt <= sent_now;
      end
      if (!in_valid || fire) begin
        if (cmd_q.size() > 0 && !(cmd_q[0].wait_drain && got_cnt != sent_now) &&
            $urandom_range(99) >= idle_pct) begin
          in_valid <= 1'b1;
          cmd      <= cmd_q[0].op;
          key_in   <= cmd_q[0].key;
          void'(cmd_q.pop_front());
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Two long hold-offs let the block back up into its input.
  always @(posedge clk) begin
    if (!rst_n) begin
      hold_left <= 0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
    end else if (out_valid && !out_stall &&
                 (got_cnt + 1 == 300 || got_cnt + 1 == 1000)) begin
      hold_left <= 400;
    end
  end

  // Receiver: checks result words and drives the output stall.
  always @(posedge clk) begin
    heap_report_t exp_r;
    int           stall_pct;
    int           errs;
    errs = 0;
    case ((got_cnt * 3) / (total_cmds + 1))
      0: stall_pct = 77;
      1: stall_pct = 17;
      default: stall_pct = 0;
    endcase
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        got_cnt <= got_cnt + 1;
        if (report_q.size() == 0) begin
          $error("result word with no pending command");
          errs++;
        end else begin
          exp_r = report_q.pop_front();
          if (status !== exp_r.status) begin
            $error("status: expected %0d, got %0d", exp_r.status, status);
            errs++;
          end
          if (min_key !== exp_r.min_key) begin
            $error("min_key: expected %0d, got %0d", $signed(exp_r.min_key),
                   $signed(min_key));
            errs++;
          end
          if (is_empty !== exp_r.is_empty) begin
            $error("is_empty: expected %0d, got %0d", exp_r.is_empty, is_empty);
            errs++;
          end
          if (entry_count !== exp_r.count) begin
            $error("entry_count: expected %0d, got %0d", exp_r.count, entry_count);
            errs++;
          end
        end
        fail_cnt <= fail_cnt + errs;
      end
      if (hold_left > 0) begin
        out_stall <= 1'b1;
      end else begin
        out_stall <= ($urandom_range(99) < stall_pct);
      end
    end
  end

  initial begin
    int gen_fill;
    int n;
    int extra;
    logic [31:0] edge_keys[10];
    edge_keys = '{32'h7FFF_FFFF, 32'h8000_0000, 32'h0, 32'hFFFF_FFFF, 32'h1,
                  32'h8000_0000, 32'h7FFF_FFFF, 32'h5, 32'h5, 32'h5555_5555};

    // Directed words: delete on empty, extreme and repeated keys, full drain.
    add_cmd(bmh_pkg::CMD_DELETE, 32'hFFFF_FFFF);
    foreach (edge_keys[i]) add_cmd(bmh_pkg::CMD_INSERT, edge_keys[i]);
    for (int i = 0; i < 11; i++) add_cmd(bmh_pkg::CMD_DELETE, 32'h0);
    add_cmd(bmh_pkg::CMD_INSERT, 32'hAAAA_AAAA);
    add_cmd(bmh_pkg::CMD_DELETE, 32'h5555_5555);
    gen_fill = 0;

    // Random part in bursts: fill past full, drain past empty, or mixed.
    while (cmd_q.size() < 1325) begin
      case ($urandom_range(3))
        0: begin
          extra = $urandom_range(1, 3);
          while (gen_fill < bmh_pkg::CAPACITY) begin
            add_cmd(bmh_pkg::CMD_INSERT, random_key());
            gen_fill++;
          end
          repeat (extra) add_cmd(bmh_pkg::CMD_INSERT, random_key());
        end
        1: begin
          extra = $urandom_range(1, 3);
          while (gen_fill > 0) begin
            add_cmd(bmh_pkg::CMD_DELETE, $urandom);
            gen_fill--;
          end
          repeat (extra) add_cmd(bmh_pkg::CMD_DELETE, $urandom);
        end
        default: begin
          n = $urandom_range(20, 60);
          repeat (n) begin
            if ($urandom_range(99) < 55) begin
              add_cmd(bmh_pkg::CMD_INSERT, random_key());
              if (gen_fill < bmh_pkg::CAPACITY) gen_fill++;
            end else begin
              add_cmd(bmh_pkg::CMD_DELETE, $urandom);
              if (gen_fill > 0) gen_fill--;
            end
          end
        end
      endcase
    end
    cmd_q[700].wait_drain = 1'b1;
    total_cmds = cmd_q.size();

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    while (sent_cnt != total_cmds || got_cnt != sent_cnt) @(posedge clk);
    repeat (40) @(posedge clk);
    if (fail_cnt == 0 && report_q.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule

FILE: sim.f
+incdir+rtl
rtl/bmh_pkg.sv
rtl/bmh_ctrl.sv
rtl/bmh_dpath.sv
rtl/binary_min_heap_queue.sv
tb/tb.sv
